// File: sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/crcpd_pkg.sv
// Package for the CRC packet deframer: opcodes, verdict codes, framing bytes
// and the byte-wide CRC-16 (polynomial 0x1021) update. Depends on nothing.
package crcpd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned CRC_W     = 16;
   localparam int unsigned TICK_W    = 16;
   localparam int unsigned VERDICT_W = 2;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [CRC_W-1:0]     crc_type;
   typedef logic [TICK_W-1:0]    tick_type;
   typedef logic [VERDICT_W-1:0] verdict_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam verdict_type V_OK      = 2'd0;
   localparam verdict_type V_CRC_BAD = 2'd1;
   localparam verdict_type V_END_BAD = 2'd2;
   localparam verdict_type V_TIMEOUT = 2'd3;

   localparam byte_type START_BYTE = 8'h02;
   localparam byte_type END_BYTE   = 8'h03;
   localparam crc_type  CRC_POLY   = 16'h1021;

   localparam tick_type TIMEOUT_RESET = 16'd100;

   function automatic crc_type crc16_byte(input crc_type crc_prev, input byte_type data);
      crc_type c;
      c = crc_prev ^ {data, 8'h00};
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[CRC_W-1]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// File: sv/crc_packet_deframer.sv
// Channel  | Direction | Handshake          | Payload
// req_     | in        | req_valid/stall    | opcode, rx_byte
// rsp_     | out       | rsp_valid/stall    | is_verdict, payload_byte, payload_index,
//          |           |                    | verdict, frame_length
// csr_     | in        | csr_we             | csr_wdata (timeout in ticks)
//
// Each transaction is processed in the cycle it is accepted; one transaction per cycle
// when not stalled. The result register holds at most one result; the input stalls only
// while it is full and the output is stalled. Reset is synchronous and returns the deframer
// to hunting with a timeout of 100 ticks. Depends on crcpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crc_packet_deframer
   import crcpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_is_verdict,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [1:0]  rsp_verdict,
   output logic [7:0]  rsp_frame_length,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_CRC_HI  = 3'd3;
   localparam logic [2:0] PH_CRC_LO  = 3'd4;
   localparam logic [2:0] PH_END     = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   byte_type    byte_count_ff, byte_count_in;
   byte_type    length_ff, length_in;
   crc_type     crc_running_ff, crc_running_in;
   crc_type     crc_received_ff, crc_received_in;
   tick_type    elapsed_ff, elapsed_in;
   tick_type    timeout_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        is_verdict_ff, is_verdict_in;
   byte_type    payload_byte_ff, payload_byte_in;
   byte_type    payload_index_ff, payload_index_in;
   verdict_type verdict_ff, verdict_in;
   byte_type    frame_length_ff, frame_length_in;

   logic        req_accept;
   logic        has_result;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      length_in        = length_ff;
      crc_running_in   = crc_running_ff;
      crc_received_in  = crc_received_ff;
      elapsed_in       = elapsed_ff;
      has_result       = 1'b0;
      is_verdict_in    = 1'b0;
      payload_byte_in  = '0;
      payload_index_in = '0;
      verdict_in       = V_OK;
      frame_length_in  = length_ff;
      if (req_accept) begin
         if (req_opcode == OP_TICK) begin
            if (phase_ff != PH_HUNT) begin
               elapsed_in = (elapsed_ff != '1) ? elapsed_ff + 16'd1 : elapsed_ff;
               if (elapsed_in >= timeout_ff) begin
                  has_result    = 1'b1;
                  is_verdict_in = 1'b1;
                  verdict_in    = V_TIMEOUT;
                  phase_in      = PH_HUNT;
               end
            end
         end else begin
            case (phase_ff)
               PH_LEN: begin
                  length_in       = req_rx_byte;
                  phase_in        = (req_rx_byte == '0) ? PH_CRC_HI : PH_PAYLOAD;
               end
               PH_PAYLOAD: begin
                  has_result       = 1'b1;
                  payload_byte_in  = req_rx_byte;
                  payload_index_in = byte_count_ff;
                  crc_running_in   = crc16_byte(crc_running_ff, req_rx_byte);
                  byte_count_in    = byte_count_ff + 8'd1;
                  if (byte_count_in >= length_ff) begin
                     phase_in = PH_CRC_HI;
                  end
               end
               PH_CRC_HI: begin
                  crc_received_in = {req_rx_byte, 8'h00};
                  phase_in        = PH_CRC_LO;
               end
               PH_CRC_LO: begin
                  crc_received_in = {crc_received_ff[15:8], req_rx_byte};
                  phase_in        = PH_END;
               end
               PH_END: begin
                  has_result    = 1'b1;
                  is_verdict_in = 1'b1;
                  phase_in      = PH_HUNT;
                  if (req_rx_byte != END_BYTE) begin
                     verdict_in = V_END_BAD;
                  end else if (crc_received_ff != crc_running_ff) begin
                     verdict_in = V_CRC_BAD;
                  end else begin
                     verdict_in = V_OK;
                  end
               end
               default: begin
                  if (req_rx_byte == START_BYTE) begin
                     phase_in        = PH_LEN;
                     byte_count_in   = '0;
                     length_in       = '0;
                     crc_running_in  = '0;
                     crc_received_in = '0;
                     elapsed_in      = '0;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
            endcase
         end
      end
      frame_length_in = is_verdict_in ? length_ff : length_in;
      rsp_valid_in    = req_accept ? has_result : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         byte_count_ff   <= '0;
         length_ff       <= '0;
         crc_running_ff  <= '0;
         crc_received_ff <= '0;
         elapsed_ff      <= '0;
         timeout_ff      <= TIMEOUT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         length_ff       <= length_in;
         crc_running_ff  <= crc_running_in;
         crc_received_ff <= crc_received_in;
         elapsed_ff      <= elapsed_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && has_result) begin
         is_verdict_ff    <= is_verdict_in;
         payload_byte_ff  <= payload_byte_in;
         payload_index_ff <= payload_index_in;
         verdict_ff       <= verdict_in;
         frame_length_ff  <= frame_length_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_verdict    = is_verdict_ff;
   assign rsp_payload_byte  = payload_byte_ff;
   assign rsp_payload_index = payload_index_ff;
   assign rsp_verdict       = verdict_ff;
   assign rsp_frame_length  = frame_length_ff;

   `ASSERT_SAME(a_stall_when_full, clock, reset, rsp_valid_ff && rsp_stall, req_stall, "Input taken while a stalled result is held.")
   `ASSERT_NEXT(a_hunt_after_verdict, clock, reset, req_accept && has_result && is_verdict_in, phase_ff == PH_HUNT, "Deframer did not return to hunting after a verdict.")
   `ASSERT_SAME(a_count_below_length, clock, reset, phase_ff == PH_PAYLOAD, byte_count_ff < length_ff, "Payload count reached the declared length while in the payload phase.")
   `ASSERT_NEXT(a_result_drains, clock, reset, rsp_valid_ff && !rsp_stall && !req_accept, !rsp_valid_ff, "Delivered result was presented again.")

endmodule
